FILE: rtl/keyvalue_section_parser_assert.svh
// Assertion macros shared by the parser modules.
// Each expects clk and rst in scope.
`ifndef KEYVALUE_SECTION_PARSER_ASSERT_SVH
`define KEYVALUE_SECTION_PARSER_ASSERT_SVH

// Same-cycle implication.
`define KVS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvs assertion failed");

// Next-cycle implication.
`define KVS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvs assertion failed");

`endif

FILE: rtl/kvs_pkg.sv
package kvs_pkg;

  localparam int unsigned MAX_DEPTH = 255;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned TLEN_W    = 17;
  localparam int unsigned TCNT_W    = 21;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned IDX_W     = $clog2(MAX_RES);
  localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);

  localparam logic [15:0] TOKEN_BYTES_RESET = 16'd32768;
  localparam logic [19:0] TOKENS_RESET      = 20'd65536;

  localparam logic REG_MAX_TOKEN_BYTES = 1'b0;
  localparam logic REG_MAX_TOKENS      = 1'b1;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_BARE    = 3'd3;
  localparam logic [2:0] M_QUOTED  = 3'd4;
  localparam logic [2:0] M_ESC     = 3'd5;

  localparam logic [2:0] EV_NAME_CHAR  = 3'd0;
  localparam logic [2:0] EV_NAME_DONE  = 3'd1;
  localparam logic [2:0] EV_VALUE_CHAR = 3'd2;
  localparam logic [2:0] EV_PAIR_DONE  = 3'd3;
  localparam logic [2:0] EV_OPEN       = 3'd4;
  localparam logic [2:0] EV_CLOSE      = 3'd5;
  localparam logic [2:0] EV_ACCEPT     = 3'd6;
  localparam logic [2:0] EV_REJECT     = 3'd7;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_OPEN      = 8'h7B;
  localparam logic [7:0] CH_CLOSE     = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic [15:0] max_token_bytes;
    logic [19:0] max_tokens;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [TLEN_W-1:0]  tlen;
    logic [TCNT_W-1:0]  tcnt;
    logic [DEPTH_W-1:0] depth;
    logic               awaiting;
    logic               rejected;
  } lex_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]            n;
    logic [MAX_RES-1:0][2:0]     ev;
    logic [MAX_RES-1:0][7:0]     ch;
  } bundle_t;

  typedef struct packed {
    lex_state_t st;
    bundle_t    res;
  } step_t;

  function automatic logic f_is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic step_t f_emit(step_t s, logic [2:0] ev, logic [7:0] c);
    step_t r;
    r = s;
    if (r.res.n < CNT_W'(MAX_RES)) begin
      r.res.ev[r.res.n[IDX_W-1:0]] = ev;
      r.res.ch[r.res.n[IDX_W-1:0]] = c;
      r.res.n = r.res.n + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic step_t f_count_token(step_t s, cfg_t cfg);
    step_t r;
    r = s;
    if (r.st.tcnt != '1) r.st.tcnt = r.st.tcnt + TCNT_W'(1);
    if (r.st.tcnt > TCNT_W'(cfg.max_tokens)) r.st.rejected = 1'b1;
    return r;
  endfunction

  function automatic step_t f_text_start(step_t s, cfg_t cfg);
    step_t r;
    r = s;
    if (!r.st.rejected) begin
      r = f_count_token(r, cfg);
      r.st.tlen = '0;
    end
    return r;
  endfunction

  function automatic step_t f_text_char(step_t s, logic [7:0] c, cfg_t cfg);
    step_t r;
    r = s;
    if (!r.st.rejected) begin
      if (r.st.tlen != '1) r.st.tlen = r.st.tlen + TLEN_W'(1);
      if (r.st.tlen > TLEN_W'(cfg.max_token_bytes)) begin
        r.st.rejected = 1'b1;
      end else begin
        r = f_emit(r, r.st.awaiting ? EV_VALUE_CHAR : EV_NAME_CHAR, c);
      end
    end
    return r;
  endfunction

  function automatic step_t f_text_end(step_t s);
    step_t r;
    r = s;
    if (!r.st.rejected) begin
      if (r.st.awaiting) begin
        r = f_emit(r, EV_PAIR_DONE, 8'h00);
        r.st.awaiting = 1'b0;
      end else begin
        r = f_emit(r, EV_NAME_DONE, 8'h00);
        r.st.awaiting = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic step_t f_brace(step_t s, logic open, cfg_t cfg);
    step_t r;
    r = s;
    if (!r.st.rejected) r = f_count_token(r, cfg);
    if (!r.st.rejected) begin
      if (open) begin
        if (!r.st.awaiting || (r.st.depth >= DEPTH_W'(MAX_DEPTH))) begin
          r.st.rejected = 1'b1;
        end else begin
          r.st.depth    = r.st.depth + DEPTH_W'(1);
          r.st.awaiting = 1'b0;
          r = f_emit(r, EV_OPEN, 8'h00);
        end
      end else begin
        if (r.st.awaiting || (r.st.depth == '0)) begin
          r.st.rejected = 1'b1;
        end else begin
          r.st.depth = r.st.depth - DEPTH_W'(1);
          r = f_emit(r, EV_CLOSE, 8'h00);
        end
      end
    end
    return r;
  endfunction

  function automatic step_t f_bare_byte(step_t s, logic [7:0] c, cfg_t cfg);
    step_t r;
    r = s;
    if (f_is_space(c)) begin
      r = f_text_end(r);
      r.st.mode = M_IDLE;
    end else if ((c == CH_OPEN) || (c == CH_CLOSE)) begin
      r = f_text_end(r);
      r.st.mode = M_IDLE;
      r = f_brace(r, c == CH_OPEN, cfg);
    end else begin
      r = f_text_char(r, c, cfg);
    end
    return r;
  endfunction

  function automatic step_t f_quoted_byte(step_t s, logic [7:0] c, cfg_t cfg);
    step_t r;
    r = s;
    if (c == CH_QUOTE) begin
      r = f_text_end(r);
      r.st.mode = M_IDLE;
    end else if (c == CH_BACKSLASH) begin
      r.st.mode = M_ESC;
    end else begin
      r = f_text_char(r, c, cfg);
    end
    return r;
  endfunction

  function automatic step_t f_idle_byte(step_t s, logic [7:0] c, cfg_t cfg);
    step_t r;
    r = s;
    if (f_is_space(c)) begin
      r = s;
    end else if (c == CH_SLASH) begin
      r.st.mode = M_SLASH;
    end else if ((c == CH_OPEN) || (c == CH_CLOSE)) begin
      r = f_brace(r, c == CH_OPEN, cfg);
    end else if (c == CH_QUOTE) begin
      r = f_text_start(r, cfg);
      r.st.mode = M_QUOTED;
    end else begin
      r = f_text_start(r, cfg);
      r.st.mode = M_BARE;
      r = f_text_char(r, c, cfg);
    end
    return r;
  endfunction

  function automatic step_t f_step(lex_state_t st, logic [7:0] c, logic last, cfg_t cfg);
    step_t r;
    r.st  = st;
    r.res = '0;
    if (!r.st.rejected) begin
      unique case (r.st.mode)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            r.st.mode = M_COMMENT;
          end else begin
            r = f_text_start(r, cfg);
            r = f_text_char(r, CH_SLASH, cfg);
            r.st.mode = M_BARE;
            r = f_bare_byte(r, c, cfg);
          end
        end
        M_COMMENT: begin
          if (c == CH_NEWLINE) r.st.mode = M_IDLE;
        end
        M_BARE:   r = f_bare_byte(r, c, cfg);
        M_QUOTED: r = f_quoted_byte(r, c, cfg);
        M_ESC: begin
          r.st.mode = M_QUOTED;
          if ((c == CH_BACKSLASH) || (c == CH_QUOTE)) begin
            r = f_text_char(r, c, cfg);
          end else begin
            r = f_text_char(r, CH_BACKSLASH, cfg);
            r = f_quoted_byte(r, c, cfg);
          end
        end
        default: begin
          r.st.mode = M_IDLE;
          r = f_idle_byte(r, c, cfg);
        end
      endcase
    end
    if (last) begin
      if (!r.st.rejected) begin
        if (r.st.mode == M_BARE) begin
          r = f_text_end(r);
        end else if (r.st.mode == M_SLASH) begin
          r = f_text_start(r, cfg);
          r = f_text_char(r, CH_SLASH, cfg);
          r = f_text_end(r);
        end else if ((r.st.mode == M_QUOTED) || (r.st.mode == M_ESC)) begin
          r.st.rejected = 1'b1;
        end
      end
      if (r.st.awaiting || (r.st.depth != '0)) r.st.rejected = 1'b1;
      r = f_emit(r, r.st.rejected ? EV_REJECT : EV_ACCEPT, 8'h00);
      r.st.mode     = M_IDLE;
      r.st.tlen     = '0;
      r.st.tcnt     = '0;
      r.st.depth    = '0;
      r.st.awaiting = 1'b0;
      r.st.rejected = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/kvs_if.sv
interface kvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_document;

  modport source (output valid, output in_byte, output end_of_document, input ready);
  modport sink (input valid, input in_byte, input end_of_document, output ready);
endinterface

interface kvs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] character;
  logic       last_of_run;

  modport source (output valid, output event_res, output character, output last_of_run,
                  input ready);
  modport sink (input valid, input event_res, input character, input last_of_run,
                output ready);
endinterface

FILE: rtl/kvs_regs.sv
module kvs_regs
  import kvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_token_bytes <= TOKEN_BYTES_RESET;
      cfg.max_tokens      <= TOKENS_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_MAX_TOKEN_BYTES: cfg.max_token_bytes <= pwdata[15:0];
        REG_MAX_TOKENS:      cfg.max_tokens      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_TOKEN_BYTES: prdata = {16'h0000, cfg.max_token_bytes};
      REG_MAX_TOKENS:      prdata = {12'h000, cfg.max_tokens};
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: rtl/kvs_lexer.sv
`include "keyvalue_section_parser_assert.svh"

module kvs_lexer
  import kvs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  kvs_in_if.sink         doc,
  output bundle_t        bundle,
  output logic           bundle_valid,
  input  logic           bundle_ready
);

  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_end;
  logic       a_adv;
  lex_state_t st;
  step_t      step;

  assign step         = f_step(st, a_byte, a_end, cfg);
  assign a_adv        = a_valid && bundle_ready;
  assign doc.ready    = !a_valid || a_adv;
  assign bundle       = step.res;
  assign bundle_valid = a_valid && (step.res.n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      st.mode     <= M_IDLE;
      st.tlen     <= '0;
      st.tcnt     <= '0;
      st.depth    <= '0;
      st.awaiting <= 1'b0;
      st.rejected <= 1'b0;
    end else begin
      if (doc.valid && doc.ready) a_valid <= 1'b1;
      else if (a_adv) a_valid <= 1'b0;
      if (a_adv) st <= step.st;
    end
  end

  // hold the item until the result side takes it
  always_ff @(posedge clk) begin
    if (doc.valid && doc.ready) begin
      a_byte <= doc.in_byte;
      a_end  <= doc.end_of_document;
    end
  end

  `KVS_ASSERT_NXT(a_doc_end_clears, a_adv && a_end, st.mode == M_IDLE && st.depth == '0 && !st.awaiting && !st.rejected && st.tcnt == '0)
  `KVS_ASSERT_IMP(a_depth_bound, 1'b1, st.depth <= DEPTH_W'(MAX_DEPTH))
  `KVS_ASSERT_IMP(a_rejected_silent, a_adv && st.rejected && !a_end, step.res.n == '0)

endmodule

FILE: rtl/kvs_out.sv
`include "keyvalue_section_parser_assert.svh"

module kvs_out
  import kvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bundle_t   bundle,
  input  logic      bundle_valid,
  output logic      bundle_ready,
  kvs_out_if.source evt
);

  logic [CNT_W-1:0]        rem;
  logic [IDX_W-1:0]        idx;
  logic [MAX_RES-1:0][2:0] ev_q;
  logic [MAX_RES-1:0][7:0] ch_q;
  logic                    fire;
  logic                    load;

  assign fire         = evt.valid && evt.ready;
  assign bundle_ready = (rem == '0) || (fire && (rem == CNT_W'(1)));
  assign load         = bundle_valid && bundle_ready;

  assign evt.valid       = rem != '0;
  assign evt.event_res   = ev_q[idx];
  assign evt.character   = ch_q[idx];
  assign evt.last_of_run = rem == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (load) begin
      rem <= bundle.n;
      idx <= '0;
    end else if (fire) begin
      rem <= rem - CNT_W'(1);
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_q <= bundle.ev;
      ch_q <= bundle.ch;
    end
  end

  `KVS_ASSERT_NXT(a_run_continues, fire && !evt.last_of_run, evt.valid)
  `KVS_ASSERT_IMP(a_rem_bound, 1'b1, rem <= CNT_W'(MAX_RES))
  `KVS_ASSERT_NXT(a_stall_holds, evt.valid && !evt.ready, evt.valid && $stable(evt.event_res) && $stable(evt.character))

endmodule

FILE: rtl/keyvalue_section_parser.sv
// Key-value section parser.
// doc carries one document byte per item, with end_of_document on the final
// byte. evt carries one event per item: name/value characters, name done,
// pair done, section open/close, and accept or reject after the final byte.
// last_of_run marks the final event caused by one byte; a byte may cause
// zero to four events.
// Path: an accepted byte is registered in the input register; once the event
// register can take them, its events are loaded there and offered on evt.
// Throughput: one byte per cycle while each byte causes at most one event
// and evt is not stalled; a byte that causes more events holds the input
// while the event register drains one event per cycle of evt.ready high.
// A receiver stall on evt holds the event register and, once the input
// register is full, drops doc.ready.
// Configuration (max_token_bytes 0x0, max_tokens 0x4) is written over APB by
// the user only while no document is in flight; the block does not check.
// Reset clears the lexer state and both registers return to their defaults.
module keyvalue_section_parser
  import kvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  kvs_in_if.sink      doc,
  kvs_out_if.source   evt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  bundle_t bundle;
  logic    bundle_valid;
  logic    bundle_ready;

  kvs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kvs_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .doc          (doc),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready)
  );

  kvs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready),
    .evt          (evt)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kvs_pkg::*;

  localparam int unsigned LIMIT = 400000;
  localparam logic [2:0] ADDR_TOKEN_BYTES = {REG_MAX_TOKEN_BYTES, 2'b00};
  localparam logic [2:0] ADDR_TOKENS      = {REG_MAX_TOKENS, 2'b00};
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_VT, CH_FF, CH_CR};
  localparam logic [7:0] SPECIALS [8] = '{CH_OPEN, CH_CLOSE, CH_QUOTE, CH_BACKSLASH,
                                          CH_SLASH, CH_NEWLINE, CH_SPACE, "a"};

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] character;
    logic       last_of_run;
  } evt_item_t;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_t;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    chk_t       kind;
    logic [2:0] ev;
    logic [7:0] ch;
  } row_t;

  localparam row_t DIRECTED [24] = '{
    '{CH_CLOSE,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{"a",          1'b1, CHK_ONE,     EV_REJECT,    8'h00},
    '{CH_SLASH,     1'b1, CHK_PREDICT, EV_NAME_CHAR, 8'h00},
    '{CH_SLASH,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_SLASH,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{8'hFF,        1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_NEWLINE,   1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{8'h00,        1'b0, CHK_ONE,     EV_NAME_CHAR, 8'h00},
    '{CH_OPEN,      1'b0, CHK_PREDICT, EV_NAME_CHAR, 8'h00},
    '{CH_QUOTE,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_BACKSLASH, 1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_QUOTE,     1'b0, CHK_ONE,     EV_NAME_CHAR, CH_QUOTE},
    '{CH_BACKSLASH, 1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{"q",          1'b0, CHK_PREDICT, EV_NAME_CHAR, 8'h00},
    '{CH_QUOTE,     1'b0, CHK_ONE,     EV_NAME_DONE, 8'h00},
    '{CH_SLASH,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_CLOSE,     1'b1, CHK_PREDICT, EV_NAME_CHAR, 8'h00},
    '{CH_QUOTE,     1'b0, CHK_NONE,    EV_NAME_CHAR, 8'h00},
    '{CH_BACKSLASH, 1'b1, CHK_ONE,     EV_REJECT,    8'h00},
    '{"k",          1'b0, CHK_ONE,     EV_NAME_CHAR, "k"},
    '{CH_OPEN,      1'b1, CHK_PREDICT, EV_NAME_CHAR, 8'h00},
    '{"x",          1'b0, CHK_ONE,     EV_NAME_CHAR, "x"},
    '{CH_SPACE,     1'b0, CHK_ONE,     EV_NAME_DONE, 8'h00},
    '{"y",          1'b1, CHK_PREDICT, EV_NAME_CHAR, 8'h00}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kvs_in_if  doc_if ();
  kvs_out_if evt_if ();

  keyvalue_section_parser dut (
    .clk     (clk),
    .rst     (rst),
    .doc     (doc_if),
    .evt     (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // lexer predictor state and limits
  logic [2:0]         lx_mode;
  logic [TLEN_W-1:0]  lx_len;
  logic [TCNT_W-1:0]  lx_count;
  logic [DEPTH_W-1:0] lx_depth;
  logic               lx_want_value;
  logic               lx_bad;
  logic [15:0]        lim_bytes;
  logic [19:0]        lim_tokens;

  evt_item_t   byte_events[$];
  evt_item_t   awaited_events[$];
  logic [7:0]  doc_text[$];
  bit          sep_owed;
  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned events_seen;
  int unsigned cycle_count;
  evt_item_t   want_item;
  evt_item_t   got_item;

  function automatic bit is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic void clear_lexer();
    lx_mode       = M_IDLE;
    lx_len        = '0;
    lx_count      = '0;
    lx_depth      = '0;
    lx_want_value = 1'b0;
    lx_bad        = 1'b0;
  endfunction

  function automatic void append_byte(input logic [7:0] c);
    doc_text.insert(doc_text.size(), c);
  endfunction

  function automatic void note_event(input logic [2:0] ev, input logic [7:0] ch);
    if (byte_events.size() < MAX_RES)
      byte_events.insert(byte_events.size(), evt_item_t'{ev, ch, 1'b0});
  endfunction

  function automatic void bump_tokens();
    if (lx_count != '1) lx_count = lx_count + 1'b1;
    if (lx_count > lim_tokens) lx_bad = 1'b1;
  endfunction

  function automatic void open_text();
    if (!lx_bad) begin
      bump_tokens();
      lx_len = '0;
    end
  endfunction

  function automatic void add_char(input logic [7:0] c);
    if (lx_bad) return;
    if (lx_len != '1) lx_len = lx_len + 1'b1;
    if (lx_len > lim_bytes) lx_bad = 1'b1;
    else note_event(lx_want_value ? EV_VALUE_CHAR : EV_NAME_CHAR, c);
  endfunction

  function automatic void close_text();
    if (lx_bad) return;
    note_event(lx_want_value ? EV_PAIR_DONE : EV_NAME_DONE, 8'h00);
    lx_want_value = !lx_want_value;
  endfunction

  function automatic void take_brace(input bit opening);
    if (lx_bad) return;
    bump_tokens();
    if (lx_bad) return;
    if (opening) begin
      if (!lx_want_value || lx_depth >= MAX_DEPTH) begin
        lx_bad = 1'b1;
      end else begin
        lx_depth      = lx_depth + 1'b1;
        lx_want_value = 1'b0;
        note_event(EV_OPEN, 8'h00);
      end
    end else if (lx_want_value || lx_depth == 0) begin
      lx_bad = 1'b1;
    end else begin
      lx_depth = lx_depth - 1'b1;
      note_event(EV_CLOSE, 8'h00);
    end
  endfunction

  function automatic void bare_in(input logic [7:0] c);
    if (is_blank(c) || c == CH_OPEN || c == CH_CLOSE) begin
      close_text();
      lx_mode = M_IDLE;
      if (!is_blank(c)) take_brace(c == CH_OPEN);
    end else begin
      add_char(c);
    end
  endfunction

  function automatic void quoted_in(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      close_text();
      lx_mode = M_IDLE;
    end else if (c == CH_BACKSLASH) begin
      lx_mode = M_ESC;
    end else begin
      add_char(c);
    end
  endfunction

  // events caused by one document byte, left in byte_events
  function automatic void lex_byte(input logic [7:0] c, input logic e);
    byte_events.delete();
    if (!lx_bad) begin
      case (lx_mode)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = M_COMMENT;
          end else begin
            open_text();
            add_char(CH_SLASH);
            lx_mode = M_BARE;
            bare_in(c);
          end
        end
        M_COMMENT: if (c == CH_NEWLINE) lx_mode = M_IDLE;
        M_BARE: bare_in(c);
        M_QUOTED: quoted_in(c);
        M_ESC: begin
          lx_mode = M_QUOTED;
          if (c == CH_BACKSLASH || c == CH_QUOTE) begin
            add_char(c);
          end else begin
            add_char(CH_BACKSLASH);
            quoted_in(c);
          end
        end
        default: begin
          lx_mode = M_IDLE;
          if (c == CH_SLASH) begin
            lx_mode = M_SLASH;
          end else if (c == CH_OPEN || c == CH_CLOSE) begin
            take_brace(c == CH_OPEN);
          end else if (c == CH_QUOTE) begin
            open_text();
            lx_mode = M_QUOTED;
          end else if (!is_blank(c)) begin
            open_text();
            lx_mode = M_BARE;
            add_char(c);
          end
        end
      endcase
    end
    if (e) begin
      if (!lx_bad) begin
        if (lx_mode == M_BARE) begin
          close_text();
        end else if (lx_mode == M_SLASH) begin
          open_text();
          add_char(CH_SLASH);
          close_text();
        end else if (lx_mode == M_QUOTED || lx_mode == M_ESC) begin
          lx_bad = 1'b1;
        end
      end
      if (lx_want_value || lx_depth != 0) lx_bad = 1'b1;
      note_event(lx_bad ? EV_REJECT : EV_ACCEPT, 8'h00);
      clear_lexer();
    end
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void put_gap();
    int unsigned n;
    logic [7:0]  c;
    n = $urandom_range(0, 2) + (sep_owed ? 1 : 0);
    sep_owed = 1'b0;
    repeat (n) append_byte(BLANKS[$urandom_range(0, 5)]);
    if ($urandom_range(0, 9) == 0) begin
      append_byte(CH_SLASH);
      append_byte(CH_SLASH);
      repeat ($urandom_range(0, 4)) begin
        c = 8'($urandom_range(0, 255));
        append_byte(c == CH_NEWLINE ? 8'h00 : c);
      end
      append_byte(CH_NEWLINE);
    end
  endfunction

  function automatic void put_text();
    int unsigned n;
    logic [7:0]  c;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
    if ($urandom_range(0, 1) == 1) begin
      append_byte(CH_QUOTE);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BACKSLASH || $urandom_range(0, 7) == 0)
          append_byte(CH_BACKSLASH);
        append_byte(c);
      end
      append_byte(CH_QUOTE);
    end else begin
      if (n == 0) n = 1;
      for (int unsigned k = 0; k < n; k++) begin
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CH_OPEN || c == CH_CLOSE ||
               (k == 0 && (c == CH_QUOTE || c == CH_SLASH)));
        append_byte(c);
      end
      sep_owed = 1'b1;
    end
  endfunction

  function automatic void make_doc();
    int unsigned n;
    int unsigned d;
    int unsigned flavour;
    logic [7:0]  c;
    doc_text.delete();
    sep_owed = 1'b0;
    flavour = $urandom_range(0, 9);
    if (flavour == 9) begin
      repeat ($urandom_range(1, 10)) begin
        c = ($urandom_range(0, 1) == 1) ? SPECIALS[$urandom_range(0, 7)] :
                                          8'($urandom_range(0, 255));
        append_byte(c);
      end
      return;
    end
    n = $urandom_range(0, 5);
    d = 0;
    while (n > 0 || d > 0) begin
      if (d > 0 && (n == 0 || $urandom_range(0, 3) == 0)) begin
        put_gap();
        append_byte(CH_CLOSE);
        d--;
      end else begin
        n--;
        put_gap();
        put_text();
        put_gap();
        if (d < 3 && $urandom_range(0, 2) == 0) begin
          append_byte(CH_OPEN);
          d++;
        end else begin
          put_text();
        end
      end
    end
    if ($urandom_range(0, 1) == 1) put_gap();
    if (doc_text.size() == 0) append_byte(CH_SPACE);
    // break a few documents
    if (flavour == 7) doc_text.delete($urandom_range(0, doc_text.size() - 1));
    if (flavour == 8)
      doc_text.insert($urandom_range(0, doc_text.size()), SPECIALS[$urandom_range(0, 7)]);
    if (doc_text.size() == 0) append_byte(CH_CLOSE);
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic e, input chk_t kind,
                            input logic [2:0] ev, input logic [7:0] ch);
    int unsigned gap;
    @(negedge clk);
    doc_if.valid           <= 1'b1;
    doc_if.in_byte         <= b;
    doc_if.end_of_document <= e;
    @(posedge clk);
    while (!doc_if.ready) @(posedge clk);
    lex_byte(b, e);
    case (kind)
      CHK_PREDICT:
        foreach (byte_events[j]) awaited_events.insert(awaited_events.size(), byte_events[j]);
      CHK_ONE: awaited_events.insert(awaited_events.size(), evt_item_t'{ev, ch, 1'b1});
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        doc_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_doc();
    for (int unsigned i = 0; i < doc_text.size(); i++)
      offer_byte(doc_text[i], i == doc_text.size() - 1, CHK_PREDICT, EV_NAME_CHAR, 8'h00);
  endtask

  task automatic run_docs(input int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      make_doc();
      send_doc();
      sent += doc_text.size();
    end
  endtask

  task automatic settle();
    @(negedge clk);
    doc_if.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    apb_access(addr, 1'b0, 32'h0, got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: reg 0x%0h expected 0x%0h actual 0x%0h", $time, addr, want, got);
    end
  endtask

  task automatic set_limits(input logic [15:0] bytes_lim, input logic [19:0] tokens_lim);
    logic [31:0] unused;
    settle();
    apb_access(ADDR_TOKEN_BYTES, 1'b1, {16'h0, bytes_lim}, unused);
    apb_access(ADDR_TOKENS, 1'b1, {12'h0, tokens_lim}, unused);
    lim_bytes  = bytes_lim;
    lim_tokens = tokens_lim;
    check_reg(ADDR_TOKEN_BYTES, {16'h0, bytes_lim});
    check_reg(ADDR_TOKENS, {12'h0, tokens_lim});
  endtask

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && evt_if.valid && evt_if.ready) begin
      events_seen++;
      got_item = evt_item_t'{evt_if.event_res, evt_if.character, evt_if.last_of_run};
      if (awaited_events.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item expected none actual ev=%0d ch=0x%0h last=%0b",
                 $time, got_item.event_res, got_item.character, got_item.last_of_run);
      end else begin
        want_item = awaited_events.pop_front();
        if (want_item.event_res !== got_item.event_res ||
            want_item.character !== got_item.character ||
            want_item.last_of_run !== got_item.last_of_run) begin
          fail_count++;
          $display("%0t: expected ev=%0d ch=0x%0h last=%0b actual ev=%0d ch=0x%0h last=%0b",
                   $time, want_item.event_res, want_item.character, want_item.last_of_run,
                   got_item.event_res, got_item.character, got_item.last_of_run);
        end
      end
    end
  end

  // receiver: changing stall styles, plus one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned style_left;
    int unsigned rx_tick;
    bit          hold_done;
    rx_style_t   style;
    hold_left  = 0;
    style_left = 0;
    rx_tick    = 0;
    hold_done  = 1'b0;
    style      = RX_FREE;
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        evt_if.ready <= 1'b0;
      end else if (!hold_done && events_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
        evt_if.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          RX_FREE:   evt_if.ready <= 1'b1;
          RX_COIN:   evt_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: evt_if.ready <= (rx_tick % 4 == 0);
          default:   evt_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    doc_if.valid           = 1'b0;
    doc_if.in_byte         = 8'h00;
    doc_if.end_of_document = 1'b0;
    fail_count  = 0;
    events_seen = 0;
    cycle_count = 0;
    burst_left  = 0;
    lim_bytes   = TOKEN_BYTES_RESET;
    lim_tokens  = TOKENS_RESET;
    clear_lexer();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    check_reg(ADDR_TOKEN_BYTES, {16'h0, TOKEN_BYTES_RESET});
    check_reg(ADDR_TOKENS, {12'h0, TOKENS_RESET});

    foreach (DIRECTED[r])
      offer_byte(DIRECTED[r].b, DIRECTED[r].eod, DIRECTED[r].kind, DIRECTED[r].ev,
                 DIRECTED[r].ch);

    run_docs(100);
    set_limits(16'd1, 20'hFFFFF);
    run_docs(45);
    set_limits(16'hFFFF, 20'd1);
    run_docs(35);
    set_limits(16'($urandom_range(2, 6)), 20'($urandom_range(3, 12)));
    run_docs(85);

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
